### rtl/core/parking_proximity_beeper_core_assert.svh
// Assertion macros shared by the proximity beeper RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef PARKING_PROXIMITY_BEEPER_CORE_ASSERT_SVH
`define PARKING_PROXIMITY_BEEPER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ppb_pkg.sv
// Shared types and constants of the proximity beeper core.
// No dependencies; used by every module of the block.
`default_nettype none

package ppb_pkg;

	localparam int THR_W   = 10;
	localparam int MS_W    = 12;
	localparam int ON_W    = 10;
	localparam int TONE_W  = 15;
	localparam int WAIT_W  = 13;
	localparam int SQ_W    = 2 * THR_W;
	localparam int PROD_W  = SQ_W + MS_W;
	localparam int NSENS   = 4;

	// Sound codes.
	localparam logic [1:0] SOUND_SILENT = 2'd0;
	localparam logic [1:0] SOUND_CONT   = 2'd1;
	localparam logic [1:0] SOUND_PULSE  = 2'd2;

	// Sensor codes.
	localparam logic [1:0] SENSOR_FRONT = 2'd0;
	localparam logic [1:0] SENSOR_LEFT  = 2'd1;
	localparam logic [1:0] SENSOR_RIGHT = 2'd2;
	localparam logic [1:0] SENSOR_BACK  = 2'd3;

	// Register indexes.
	localparam logic [2:0] REG_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_MIN_OFF    = 3'd1;
	localparam logic [2:0] REG_MAX_OFF    = 3'd2;
	localparam logic [2:0] REG_BEEP_ON    = 3'd3;
	localparam logic [2:0] REG_TONE_FRONT = 3'd4;
	localparam logic [2:0] REG_TONE_LEFT  = 3'd5;
	localparam logic [2:0] REG_TONE_RIGHT = 3'd6;
	localparam logic [2:0] REG_TONE_BACK  = 3'd7;

	// Reset values.
	localparam logic [THR_W-1:0]  RST_THRESHOLD  = 10'd50;
	localparam logic [MS_W-1:0]   RST_MIN_OFF    = 12'd50;
	localparam logic [MS_W-1:0]   RST_MAX_OFF    = 12'd500;
	localparam logic [ON_W-1:0]   RST_BEEP_ON    = 10'd50;
	localparam logic [TONE_W-1:0] RST_TONE_FRONT = 15'd1000;
	localparam logic [TONE_W-1:0] RST_TONE_LEFT  = 15'd800;
	localparam logic [TONE_W-1:0] RST_TONE_RIGHT = 15'd1200;
	localparam logic [TONE_W-1:0] RST_TONE_BACK  = 15'd600;

	localparam logic [THR_W-1:0]  NEAR_LIMIT   = 10'd4;
	localparam logic [THR_W:0]    SPEED_LIMIT  = 11'd5;
	localparam logic [WAIT_W-1:0] IDLE_WAIT_MS = 13'd100;

	typedef struct packed {
		logic [THR_W-1:0]              threshold;
		logic [MS_W-1:0]               min_off;
		logic [MS_W-1:0]               max_off;
		logic [ON_W-1:0]               beep_on;
		logic [NSENS-1:0][TONE_W-1:0]  tone;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [THR_W-1:0]  best;
		logic [THR_W-1:0]  thr;
		logic [MS_W-1:0]   diff;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MS_W-1:0]  quo;
	} div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/parking_proximity_beeper_core.sv
// Top level of the parking proximity beeper: nearest-sensor pick, beep plan
// and result register. Uses ppb_pkg, ppb_cfg_regs and ppb_offdiv.
//
// Usage:
//   Input beats carry four distances (dist_front, dist_left, dist_right,
//   dist_back); a zero distance is no reading. Each accepted beat yields
//   exactly one result beat (sound, tone_hz, on_ms, wait_ms, nearest_sensor,
//   nearest_dist). Both channels use valid/stall; a beat moves when valid is
//   high and stall is low.
//   Silent and continuous-tone samples pass from acceptance to the done
//   state, from which the result is registered into the output register.
//   Pulsed samples first run the off-time scaling unit (three passes
//   through the shared multiplier, then twelve divider steps) in the calc
//   state. in_stall is high while an item is in work.
//   When the receiver stalls, the result waits in the output register and
//   the finished item holds the block until that register frees.
//   Reset loads all configuration registers with their documented defaults,
//   clears the output valid and sets the kept distance to 50.
//   Configuration is to be written through the APB port while the block is idle; the block does not enforce it.
`default_nettype none

module parking_proximity_beeper_core #(
	parameter int DIST_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [4:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// sample channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [DIST_BITS-1:0]  dist_front,
	input  wire logic [DIST_BITS-1:0]  dist_left,
	input  wire logic [DIST_BITS-1:0]  dist_right,
	input  wire logic [DIST_BITS-1:0]  dist_back,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 sound,
	output logic [14:0]                tone_hz,
	output logic [9:0]                 on_ms,
	output logic [12:0]                wait_ms,
	output logic [1:0]                 nearest_sensor,
	output logic [9:0]                 nearest_dist
);

	`include "parking_proximity_beeper_core_assert.svh"

	localparam int THR_W  = ppb_pkg::THR_W;
	localparam int WAIT_W = ppb_pkg::WAIT_W;
	localparam int CMP_W  = (DIST_BITS > THR_W) ? DIST_BITS : THR_W;

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_DONE} state_t;

	ppb_pkg::cfg_t     cfg;
	ppb_pkg::div_req_t div_req;
	ppb_pkg::div_rsp_t div_rsp;

	ppb_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t                      st_q;
	logic [THR_W-1:0]            last_q;
	logic                        halve_q;
	logic                        start_q;
	logic [1:0]                  snd_q;
	logic [ppb_pkg::TONE_W-1:0]  tone_q;
	logic [1:0]                  sens_q;
	logic [THR_W-1:0]            dist_q;
	logic [ppb_pkg::ON_W-1:0]    on_q;
	logic [WAIT_W-1:0]           wait_q;
	logic                        out_valid_q;

	logic [CMP_W-1:0] d_ext [ppb_pkg::NSENS];
	logic [CMP_W-1:0] thr_ext;
	logic [CMP_W-1:0] best_ext;
	logic [THR_W-1:0] best;
	logic [1:0]       sel;
	logic             found;
	logic             accept;
	logic             out_free;
	logic [WAIT_W-1:0] off_full;
	logic [WAIT_W-1:0] off_adj;
	logic [WAIT_W-1:0] wait_pulse;

	assign d_ext[0] = CMP_W'(dist_front);
	assign d_ext[1] = CMP_W'(dist_left);
	assign d_ext[2] = CMP_W'(dist_right);
	assign d_ext[3] = CMP_W'(dist_back);
	assign thr_ext  = CMP_W'(cfg.threshold);

	// Nearest valid reading below the threshold; strict compare keeps the
	// earlier sensor on a tie.
	always_comb begin
		found    = 1'b0;
		best_ext = '0;
		sel      = ppb_pkg::SENSOR_FRONT;
		for (int i = 0; i < ppb_pkg::NSENS; i++) begin
			if (d_ext[i] != '0 && d_ext[i] < thr_ext && (!found || d_ext[i] < best_ext)) begin
				found    = 1'b1;
				best_ext = d_ext[i];
				sel      = 2'(i);
			end
		end
	end

	// best is below a 10-bit threshold, so the low bits hold it exactly.
	assign best     = best_ext[THR_W-1:0];
	assign in_stall = (st_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign div_req.start = start_q;
	assign div_req.best  = dist_q;
	assign div_req.thr   = cfg.threshold;
	assign div_req.diff  = (cfg.max_off > cfg.min_off) ? (cfg.max_off - cfg.min_off) : '0;

	ppb_offdiv u_offdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign off_full   = WAIT_W'(cfg.min_off) + WAIT_W'(div_rsp.quo);
	assign off_adj    = halve_q ? (off_full >> 1) : off_full;
	assign wait_pulse = WAIT_W'(cfg.beep_on) + off_adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			last_q      <= ppb_pkg::RST_THRESHOLD;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						dist_q <= best;
						sens_q <= sel;
						tone_q <= cfg.tone[sel];
						if (!found) begin
							snd_q  <= ppb_pkg::SOUND_SILENT;
							tone_q <= '0;
							sens_q <= ppb_pkg::SENSOR_FRONT;
							dist_q <= '0;
							on_q   <= '0;
							wait_q <= ppb_pkg::IDLE_WAIT_MS;
							last_q <= cfg.threshold;
							st_q   <= S_DONE;
						end else if (best < ppb_pkg::NEAR_LIMIT) begin
							snd_q  <= ppb_pkg::SOUND_CONT;
							on_q   <= '0;
							wait_q <= ppb_pkg::IDLE_WAIT_MS;
							st_q   <= S_DONE;
						end else begin
							snd_q   <= ppb_pkg::SOUND_PULSE;
							on_q    <= cfg.beep_on;
							halve_q <= ({1'b0, last_q} > ({1'b0, best} + ppb_pkg::SPEED_LIMIT));
							last_q  <= best;
							start_q <= 1'b1;
							st_q    <= S_CALC;
						end
					end
				end
				S_CALC: begin
					if (div_rsp.done) begin
						wait_q <= wait_pulse;
						st_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						sound          <= snd_q;
						tone_hz        <= tone_q;
						on_ms          <= on_q;
						wait_ms        <= wait_q;
						nearest_sensor <= sens_q;
						nearest_dist   <= dist_q;
						out_valid_q    <= 1'b1;
						st_q           <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`PPB_ASSERT_NEXT(a_accept_busy, accept, in_stall, "block not busy after accepting a sample")
	`PPB_ASSERT_IMPLY(a_silent_zero, out_valid && sound == ppb_pkg::SOUND_SILENT, tone_hz == '0 && nearest_dist == '0 && on_ms == '0, "silent result with nonzero fields")
	`PPB_ASSERT_IMPLY(a_pulse_far, out_valid && sound == ppb_pkg::SOUND_PULSE, nearest_dist >= ppb_pkg::NEAR_LIMIT, "pulsed result for a very near obstacle")
	`PPB_ASSERT_IMPLY(a_fixed_wait, out_valid && sound != ppb_pkg::SOUND_PULSE, wait_ms == ppb_pkg::IDLE_WAIT_MS, "non-pulsed result with wrong wait")

endmodule

`default_nettype wire

### rtl/core/ppb_cfg_regs.sv
// APB-style configuration register file of the proximity beeper.
// Depends on ppb_pkg for the register layout and reset values.
`default_nettype none

module ppb_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output ppb_pkg::cfg_t     cfg
);

	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.threshold <= ppb_pkg::RST_THRESHOLD;
			cfg.min_off   <= ppb_pkg::RST_MIN_OFF;
			cfg.max_off   <= ppb_pkg::RST_MAX_OFF;
			cfg.beep_on   <= ppb_pkg::RST_BEEP_ON;
			cfg.tone[0]   <= ppb_pkg::RST_TONE_FRONT;
			cfg.tone[1]   <= ppb_pkg::RST_TONE_LEFT;
			cfg.tone[2]   <= ppb_pkg::RST_TONE_RIGHT;
			cfg.tone[3]   <= ppb_pkg::RST_TONE_BACK;
		end else if (wr_en) begin
			case (idx)
				ppb_pkg::REG_THRESHOLD:  cfg.threshold <= pwdata[ppb_pkg::THR_W-1:0];
				ppb_pkg::REG_MIN_OFF:    cfg.min_off   <= pwdata[ppb_pkg::MS_W-1:0];
				ppb_pkg::REG_MAX_OFF:    cfg.max_off   <= pwdata[ppb_pkg::MS_W-1:0];
				ppb_pkg::REG_BEEP_ON:    cfg.beep_on   <= pwdata[ppb_pkg::ON_W-1:0];
				ppb_pkg::REG_TONE_FRONT: cfg.tone[0]   <= pwdata[ppb_pkg::TONE_W-1:0];
				ppb_pkg::REG_TONE_LEFT:  cfg.tone[1]   <= pwdata[ppb_pkg::TONE_W-1:0];
				ppb_pkg::REG_TONE_RIGHT: cfg.tone[2]   <= pwdata[ppb_pkg::TONE_W-1:0];
				ppb_pkg::REG_TONE_BACK:  cfg.tone[3]   <= pwdata[ppb_pkg::TONE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ppb_pkg::REG_THRESHOLD:  prdata = 32'(cfg.threshold);
			ppb_pkg::REG_MIN_OFF:    prdata = 32'(cfg.min_off);
			ppb_pkg::REG_MAX_OFF:    prdata = 32'(cfg.max_off);
			ppb_pkg::REG_BEEP_ON:    prdata = 32'(cfg.beep_on);
			ppb_pkg::REG_TONE_FRONT: prdata = 32'(cfg.tone[0]);
			ppb_pkg::REG_TONE_LEFT:  prdata = 32'(cfg.tone[1]);
			ppb_pkg::REG_TONE_RIGHT: prdata = 32'(cfg.tone[2]);
			ppb_pkg::REG_TONE_BACK:  prdata = 32'(cfg.tone[3]);
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/ppb_offdiv.sv
// Off-time scaling unit: one shared multiplier for d*d, thr*thr and d*d*diff,
// then a restoring divider producing one quotient bit a cycle. Uses ppb_pkg.
`default_nettype none

module ppb_offdiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ppb_pkg::div_req_t req,
	output ppb_pkg::div_rsp_t      rsp
);

	`include "parking_proximity_beeper_core_assert.svh"

	typedef enum logic [2:0] {S_IDLE, S_SQ, S_DEN, S_NUM, S_DIV} state_t;

	localparam int SQ_W   = ppb_pkg::SQ_W;
	localparam int MS_W   = ppb_pkg::MS_W;
	localparam int PROD_W = ppb_pkg::PROD_W;

	state_t                    st_q;
	logic [ppb_pkg::THR_W-1:0] best_q;
	logic [ppb_pkg::THR_W-1:0] thr_q;
	logic [MS_W-1:0]           diff_q;
	logic [SQ_W-1:0]           sq_q;
	logic [SQ_W-1:0]           den_q;
	logic [SQ_W-1:0]           rem_q;
	logic [MS_W-1:0]           lq_q;
	logic [3:0]                cnt_q;
	logic                      done_q;

	logic [SQ_W-1:0]   mul_a;
	logic [MS_W-1:0]   mul_b;
	logic [PROD_W-1:0] prod;
	logic [SQ_W+1:0]   trial;
	logic              ge;

	// Operand select for the shared multiplier.
	always_comb begin
		case (st_q)
			S_SQ: begin
				mul_a = SQ_W'(best_q);
				mul_b = MS_W'(best_q);
			end
			S_DEN: begin
				mul_a = SQ_W'(thr_q);
				mul_b = MS_W'(thr_q);
			end
			S_NUM: begin
				mul_a = sq_q;
				mul_b = diff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign trial = {1'b0, rem_q, lq_q[MS_W-1]} - {2'b00, den_q};
	assign ge    = !trial[SQ_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (req.start) begin
						best_q <= req.best;
						thr_q  <= req.thr;
						diff_q <= req.diff;
						st_q   <= S_SQ;
					end
				end
				S_SQ: begin
					sq_q <= prod[SQ_W-1:0];
					st_q <= S_DEN;
				end
				S_DEN: begin
					den_q <= prod[SQ_W-1:0];
					st_q  <= S_NUM;
				end
				S_NUM: begin
					// The quotient stays below 2^12 because d is below the threshold,
					// so the top bits of the product already sit below the divisor.
					rem_q <= prod[PROD_W-1:MS_W];
					lq_q  <= prod[MS_W-1:0];
					cnt_q <= '0;
					st_q  <= S_DIV;
				end
				S_DIV: begin
					rem_q <= ge ? trial[SQ_W-1:0] : {rem_q[SQ_W-2:0], lq_q[MS_W-1]};
					lq_q  <= {lq_q[MS_W-2:0], ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(MS_W - 1)) begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = lq_q;

	`PPB_ASSERT_IMPLY(a_start_idle, req.start, st_q == S_IDLE, "start while unit busy")
	`PPB_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
	`PPB_ASSERT_IMPLY(a_rem_below, st_q == S_DIV, rem_q < den_q, "remainder not below divisor")

endmodule

`default_nettype wire

### dv/tb_parking_proximity_beeper_core.sv
// Self-checking testbench for parking_proximity_beeper_core: random and directed
// distance samples against an in-bench beep planner, with APB register programming.
// Depends on ppb_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_parking_proximity_beeper_core;
	import ppb_pkg::*;

	typedef struct packed {
		logic [THR_W-1:0] front;
		logic [THR_W-1:0] left;
		logic [THR_W-1:0] right;
		logic [THR_W-1:0] back;
	} sample_t;

	typedef struct packed {
		logic [1:0]        sound;
		logic [TONE_W-1:0] tone_hz;
		logic [ON_W-1:0]   on_ms;
		logic [WAIT_W-1:0] wait_ms;
		logic [1:0]        sensor;
		logic [THR_W-1:0]  near_dist;
	} beep_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [THR_W-1:0] dist_front = '0;
	logic [THR_W-1:0] dist_left = '0;
	logic [THR_W-1:0] dist_right = '0;
	logic [THR_W-1:0] dist_back = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] sound;
	logic [14:0] tone_hz;
	logic [9:0] on_ms;
	logic [12:0] wait_ms;
	logic [1:0] nearest_sensor;
	logic [9:0] nearest_dist;

	parking_proximity_beeper_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.dist_front(dist_front), .dist_left(dist_left),
		.dist_right(dist_right), .dist_back(dist_back),
		.out_valid(out_valid), .out_stall(out_stall),
		.sound(sound), .tone_hz(tone_hz), .on_ms(on_ms), .wait_ms(wait_ms),
		.nearest_sensor(nearest_sensor), .nearest_dist(nearest_dist)
	);

	// Planner state: register copies and the kept distance.
	logic [THR_W-1:0] cfg_thr;
	logic [MS_W-1:0] cfg_min_off;
	logic [MS_W-1:0] cfg_max_off;
	logic [ON_W-1:0] cfg_beep_on;
	logic [TONE_W-1:0] cfg_tone [NSENS];
	logic [THR_W-1:0] kept_dist;

	sample_t samples_to_send [$];
	beep_t planned_beeps [$];
	bit in_fire;
	int gap_pct = 19;
	int stall_pct = 19;
	int n_mismatch = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic beep_t plan_beep(input sample_t s);
		logic [THR_W-1:0] d [NSENS];
		logic [1:0] pick;
		logic found;
		longint unsigned best, thr, diff, off;
		beep_t r;
		d[SENSOR_FRONT] = s.front;
		d[SENSOR_LEFT] = s.left;
		d[SENSOR_RIGHT] = s.right;
		d[SENSOR_BACK] = s.back;
		found = 1'b0;
		pick = SENSOR_FRONT;
		r = '0;
		// Strict less-than keeps the earlier sensor on a tie.
		for (int i = 0; i < NSENS; i++) begin
			if (d[i] != 0 && d[i] < cfg_thr && (!found || d[i] < d[pick])) begin
				found = 1'b1;
				pick = i[1:0];
			end
		end
		if (!found) begin
			r.sound = SOUND_SILENT;
			r.wait_ms = IDLE_WAIT_MS;
			kept_dist = cfg_thr;
			return r;
		end
		r.tone_hz = cfg_tone[pick];
		r.sensor = pick;
		r.near_dist = d[pick];
		if (d[pick] < NEAR_LIMIT) begin
			r.sound = SOUND_CONT;
			r.wait_ms = IDLE_WAIT_MS;
		end else begin
			best = d[pick];
			thr = cfg_thr;
			diff = (cfg_max_off > cfg_min_off) ? cfg_max_off - cfg_min_off : 0;
			off = cfg_min_off;
			if (thr != 0)
				off += best * best * diff / (thr * thr);
			if (int'(kept_dist) - int'(d[pick]) > int'(SPEED_LIMIT))
				off = off / 2;
			kept_dist = d[pick];
			r.sound = SOUND_PULSE;
			r.on_ms = cfg_beep_on;
			r.wait_ms = WAIT_W'(longint'(cfg_beep_on) + off);
		end
		return r;
	endfunction

	function automatic logic [31:0] reg_value(input logic [2:0] idx);
		case (idx)
			REG_THRESHOLD:  return 32'(cfg_thr);
			REG_MIN_OFF:    return 32'(cfg_min_off);
			REG_MAX_OFF:    return 32'(cfg_max_off);
			REG_BEEP_ON:    return 32'(cfg_beep_on);
			REG_TONE_FRONT: return 32'(cfg_tone[SENSOR_FRONT]);
			REG_TONE_LEFT:  return 32'(cfg_tone[SENSOR_LEFT]);
			REG_TONE_RIGHT: return 32'(cfg_tone[SENSOR_RIGHT]);
			default:        return 32'(cfg_tone[SENSOR_BACK]);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input longint unsigned exp_v,
			input longint unsigned act_v);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
	endtask

	// Input side: a new beat is offered only once the previous one has moved; out_stall is also drawn at random here.
	always @(negedge clk) begin
		sample_t s;
		if (!in_valid || in_fire) begin
			if (samples_to_send.size() > 0 && $urandom_range(99) >= gap_pct) begin
				s = samples_to_send.pop_front();
				dist_front <= s.front;
				dist_left <= s.left;
				dist_right <= s.right;
				dist_back <= s.back;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		beep_t exp_b;
		in_fire = in_valid && !in_stall;
		if (in_fire)
			planned_beeps.push_back(plan_beep({dist_front, dist_left, dist_right, dist_back}));
		if (out_valid && !out_stall) begin
			if (planned_beeps.size() == 0) begin
				note_mismatch("unexpected result beat, sound", 0, sound);
			end else begin
				exp_b = planned_beeps.pop_front();
				if (sound !== exp_b.sound)
					note_mismatch("sound", exp_b.sound, sound);
				if (tone_hz !== exp_b.tone_hz)
					note_mismatch("tone_hz", exp_b.tone_hz, tone_hz);
				if (on_ms !== exp_b.on_ms)
					note_mismatch("on_ms", exp_b.on_ms, on_ms);
				if (wait_ms !== exp_b.wait_ms)
					note_mismatch("wait_ms", exp_b.wait_ms, wait_ms);
				if (nearest_sensor !== exp_b.sensor)
					note_mismatch("nearest_sensor", exp_b.sensor, nearest_sensor);
				if (nearest_dist !== exp_b.near_dist)
					note_mismatch("nearest_dist", exp_b.near_dist, nearest_dist);
			end
		end
	end

	// Write one register, then read it back.
	task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_THRESHOLD:  cfg_thr = val[THR_W-1:0];
			REG_MIN_OFF:    cfg_min_off = val[MS_W-1:0];
			REG_MAX_OFF:    cfg_max_off = val[MS_W-1:0];
			REG_BEEP_ON:    cfg_beep_on = val[ON_W-1:0];
			REG_TONE_FRONT: cfg_tone[SENSOR_FRONT] = val[TONE_W-1:0];
			REG_TONE_LEFT:  cfg_tone[SENSOR_LEFT] = val[TONE_W-1:0];
			REG_TONE_RIGHT: cfg_tone[SENSOR_RIGHT] = val[TONE_W-1:0];
			default:        cfg_tone[SENSOR_BACK] = val[TONE_W-1:0];
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_value(idx))
			note_mismatch("register readback", reg_value(idx), prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input int thr, input int min_off, input int max_off,
			input int beep_on, input int t_front, input int t_left, input int t_right,
			input int t_back);
		program_reg(REG_THRESHOLD, thr);
		program_reg(REG_MIN_OFF, min_off);
		program_reg(REG_MAX_OFF, max_off);
		program_reg(REG_BEEP_ON, beep_on);
		program_reg(REG_TONE_FRONT, t_front);
		program_reg(REG_TONE_LEFT, t_left);
		program_reg(REG_TONE_RIGHT, t_right);
		program_reg(REG_TONE_BACK, t_back);
	endtask

	// Waits until every sample has moved and every result has come back.
	task automatic wait_drained();
		while (samples_to_send.size() > 0 || in_valid || planned_beeps.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_sample(input int f, input int l, input int r, input int b);
		samples_to_send.push_back({THR_W'(f), THR_W'(l), THR_W'(r), THR_W'(b)});
	endtask

	function automatic int noise_dist(input int thr);
		int hi;
		hi = (thr > 0 && thr < 1021) ? thr + 2 : 1023;
		case ($urandom_range(4))
			0:       return 0;
			1:       return $urandom_range(1023);
			default: return $urandom_range(hi, 1);
		endcase
	endfunction

	// Mostly approach runs on one sensor, with noise samples mixed in.
	task automatic queue_traffic(input int n, input int thr);
		int made, lead, d, run_len;
		int v [NSENS];
		made = 0;
		while (made < n) begin
			if ($urandom_range(9) < 3) begin
				push_sample(noise_dist(thr), noise_dist(thr), noise_dist(thr), noise_dist(thr));
				made++;
			end else begin
				lead = $urandom_range(NSENS - 1);
				d = (thr > 1) ? $urandom_range(thr, 1) : 1;
				run_len = $urandom_range(12, 3);
				for (int k = 0; k < run_len && made < n; k++) begin
					for (int i = 0; i < NSENS; i++) begin
						case ($urandom_range(3))
							0:       v[i] = 0;
							1:       v[i] = $urandom_range(1023);
							2:       v[i] = (d + $urandom_range(3) > 1023) ? 1023 : d + $urandom_range(3);
							default: v[i] = noise_dist(thr);
						endcase
					end
					v[lead] = d;
					push_sample(v[SENSOR_FRONT], v[SENSOR_LEFT], v[SENSOR_RIGHT], v[SENSOR_BACK]);
					made++;
					d = d - $urandom_range(9);
					if (d < 1)
						d = 1;
				end
			end
		end
	endtask

	initial begin
		int thr;
		cfg_thr = RST_THRESHOLD;
		cfg_min_off = RST_MIN_OFF;
		cfg_max_off = RST_MAX_OFF;
		cfg_beep_on = RST_BEEP_ON;
		cfg_tone[SENSOR_FRONT] = RST_TONE_FRONT;
		cfg_tone[SENSOR_LEFT] = RST_TONE_LEFT;
		cfg_tone[SENSOR_RIGHT] = RST_TONE_RIGHT;
		cfg_tone[SENSOR_BACK] = RST_TONE_BACK;
		kept_dist = RST_THRESHOLD;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed samples under the reset settings (threshold 50).
		push_sample(0, 0, 0, 0);
		push_sample(1023, 1023, 1023, 1023);
		push_sample(50, 50, 50, 50);
		push_sample(49, 0, 0, 0);
		push_sample(0, 1, 0, 0);
		push_sample(0, 0, 3, 0);
		push_sample(0, 0, 0, 4);
		push_sample(10, 10, 10, 10);
		push_sample(0, 20, 20, 0);
		push_sample(0, 0, 20, 20);
		push_sample(30, 0, 0, 0);
		push_sample(24, 0, 0, 0);
		push_sample(19, 0, 0, 0);
		push_sample(12, 13, 11, 0);
		push_sample(0, 0, 0, 7);
		push_sample(512, 1, 600, 0);
		push_sample(2, 1, 3, 1);
		push_sample(0, 0, 0, 0);
		push_sample(44, 0, 0, 0);
		push_sample(1023, 0, 0, 0);
		queue_traffic(120, cfg_thr);
		wait_drained();
		// The sender was held back until everything came out; resume.
		queue_traffic(130, cfg_thr);
		wait_drained();

		// Widest threshold and off range, no idling on either side.
		set_config(1023, 0, 4095, 1023, 20000, 0, 1, 16384);
		gap_pct = 0;
		stall_pct = 0;
		queue_traffic(150, cfg_thr);
		wait_drained();
		gap_pct = 19;
		stall_pct = 19;

		// Minimum above maximum floors the range at zero.
		set_config(5, 4095, 0, 0, 0, 20000, 7, 3);
		push_sample(0, 0, 0, 4);
		push_sample(1, 2, 3, 4);
		queue_traffic(60, cfg_thr);
		wait_drained();

		set_config(1, 4095, 4095, 1023, 1, 2, 3, 4);
		queue_traffic(20, 2);
		wait_drained();

		// A zero threshold silences every sample.
		set_config(0, 100, 200, 10, 500, 600, 700, 800);
		push_sample(1, 1, 1, 1);
		queue_traffic(20, 8);
		wait_drained();

		repeat (3) begin
			thr = ($urandom_range(1)) ? $urandom_range(1023, 1) : $urandom_range(64, 4);
			set_config(thr, $urandom_range(4095), $urandom_range(4095), $urandom_range(1023),
				$urandom_range(20000), $urandom_range(20000), $urandom_range(20000),
				$urandom_range(20000));
			queue_traffic(80, thr);
			wait_drained();
		end

		if (planned_beeps.size() > 0)
			note_mismatch("missing result beats", 0, planned_beeps.size());
		if (n_mismatch == 0)
			$display("** parking_proximity_beeper_core: PASSED **");
		else
			$display("** parking_proximity_beeper_core: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** parking_proximity_beeper_core: FAILED **");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ppb_pkg.sv
rtl/core/ppb_cfg_regs.sv
rtl/core/ppb_offdiv.sv
rtl/core/parking_proximity_beeper_core.sv
dv/tb_parking_proximity_beeper_core.sv
